// ===== sv/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the result item type, the decoder output bundle and the fixed constants.
// No dependencies.
`default_nettype none

package u8u16_pkg;

   localparam int CODE_W      = 21;
   localparam int QUEUE_DEPTH = 3;

   localparam logic [1:0]        REM_NONE       = 2'd0;
   localparam logic [1:0]        REM_ONE        = 2'd1;
   localparam logic [1:0]        REM_TWO        = 2'd2;
   localparam logic [1:0]        REM_THREE      = 2'd3;
   localparam logic [CODE_W-1:0] BMP_LOW_MAX    = 21'h00D7FF;
   localparam logic [CODE_W-1:0] BMP_HIGH_MIN   = 21'h00E000;
   localparam logic [CODE_W-1:0] BMP_MAX        = 21'h00FFFF;
   localparam logic [CODE_W-1:0] SUPP_BASE      = 21'h010000;
   localparam logic [15:0]       HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0]       LOW_SURR_BASE  = 16'hDC00;

   typedef struct packed {
      logic [CODE_W-1:0] code_unit;
      logic              unit_valid;
      logic              end_of_string;
      logic              truncated;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } decode_out_type;

endpackage

`default_nettype wire

// ===== sv/u8u16_channels.sv =====
// Handshake channel interfaces of the transcoder: byte input, result output
// and the mode register write port. Depends on u8u16_pkg for the code width.
`default_nettype none

interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;
   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface u8u16_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [u8u16_pkg::CODE_W-1:0]    code_unit;
   logic                            unit_valid;
   logic                            end_of_string;
   logic                            truncated;
   modport source (output valid, output code_unit, output unit_valid,
                   output end_of_string, output truncated, input ready);
   modport sink (input valid, input code_unit, input unit_valid,
                 input end_of_string, input truncated, output ready);
endinterface

interface u8u16_csr_if;
   logic valid;
   logic ready;
   logic output_utf32;
   modport source (output valid, output output_utf32, input ready);
   modport sink (input valid, input output_utf32, output ready);
endinterface

`default_nettype wire

// ===== sv/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16/UTF-32 transcoder: input register, mode
// register, decoder and result queue. Depends on u8u16_pkg, u8u16_channels,
// u8u16_decode and u8u16_out_queue.
//
//  channel | dir | payload                                          | transfer
//  req     | in  | byte_in[7:0], last_byte                          | valid & ready
//  rsp     | out | code_unit[20:0], unit_valid, end_of_string, trunc | valid & ready
//  csr     | in  | output_utf32                                     | valid & ready
//
// One byte per cycle sustained while req is not stalled; a surrogate pair adds one rsp beat.
// After the byte transfer, the first result passes the input register, then the
// result queue register, before it can transfer on rsp.
// req stalls only while the three-entry result queue holds two or more results.
// Synchronous reset clears sequence state, queue and mode (UTF-16).
// csr is always ready.
`default_nettype none

module utf8_to_utf16_transcoder (
   input  wire logic    clock,
   input  wire logic    reset,
   u8u16_req_if.sink    req,
   u8u16_rsp_if.source  rsp,
   u8u16_csr_if.sink    csr
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;
   logic       mode_ff, mode_in;
   logic       room;
   logic       consume;
   logic       req_take;
   u8u16_pkg::decode_out_type dec_out;

   assign consume   = in_valid_ff && room;
   assign req.ready = !in_valid_ff || room;
   assign req_take  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
      in_byte_in  = req_take ? req.byte_in : in_byte_ff;
      in_last_in  = req_take ? req.last_byte : in_last_ff;
      mode_in     = (csr.valid && csr.ready) ? csr.output_utf32 : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   u8u16_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .consume      (consume),
      .byte_in      (in_byte_ff),
      .last_byte    (in_last_ff),
      .output_utf32 (mode_ff),
      .dec_out      (dec_out)
   );

   u8u16_out_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (consume),
      .dec_out (dec_out),
      .room    (room),
      .rsp     (rsp)
   );

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("pending byte lost while stalled");
   a_no_take_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |-> !req_take)
      else $error("byte taken over a pending one");
   a_mode_change: assert property (@(posedge clock) disable iff (reset)
      !(csr.valid && csr.ready) |=> $stable(mode_ff))
      else $error("mode changed without a csr transfer");

endmodule

`default_nettype wire

// ===== sv/u8u16_decode.sv =====
// Byte decoder: sequence state registers plus the code point to code unit logic.
// Produces up to two results per consumed byte. Depends on u8u16_pkg.
`default_nettype none

module u8u16_decode (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      consume,
   input  wire logic [7:0]                byte_in,
   input  wire logic                      last_byte,
   input  wire logic                      output_utf32,
   output u8u16_pkg::decode_out_type      dec_out
);

   logic [1:0]                         rem_ff, rem_in;
   logic [u8u16_pkg::CODE_W-1:0]       gath_ff, gath_in;
   logic [1:0]                         rem_next;
   logic [u8u16_pkg::CODE_W-1:0]       gath_next;
   logic [u8u16_pkg::CODE_W-1:0]       supp_off;
   u8u16_pkg::result_type              marker;

   always_comb begin
      if (rem_ff == u8u16_pkg::REM_NONE) begin
         if (byte_in[7] == 1'b0) begin
            gath_next = {13'd0, byte_in};
            rem_next  = u8u16_pkg::REM_NONE;
         end else if (byte_in[7:5] == 3'b110) begin
            gath_next = {16'd0, byte_in[4:0]};
            rem_next  = u8u16_pkg::REM_ONE;
         end else if (byte_in[7:4] == 4'b1110) begin
            gath_next = {17'd0, byte_in[3:0]};
            rem_next  = u8u16_pkg::REM_TWO;
         end else begin
            gath_next = {18'd0, byte_in[2:0]};
            rem_next  = u8u16_pkg::REM_THREE;
         end
      end else begin
         gath_next = {gath_ff[14:0], byte_in[5:0]};
         rem_next  = rem_ff - 2'd1;
      end
   end

   assign supp_off = gath_next - u8u16_pkg::SUPP_BASE;

   always_comb begin
      marker               = '0;
      marker.end_of_string = 1'b1;
      dec_out              = '0;
      if (rem_next != u8u16_pkg::REM_NONE) begin
         if (last_byte) begin
            dec_out.count           = 2'd1;
            dec_out.first           = marker;
            dec_out.first.truncated = 1'b1;
         end
      end else if (output_utf32 || gath_next <= u8u16_pkg::BMP_LOW_MAX ||
                   (gath_next >= u8u16_pkg::BMP_HIGH_MIN &&
                    gath_next <= u8u16_pkg::BMP_MAX)) begin
         dec_out.count               = 2'd1;
         dec_out.first.code_unit     = gath_next;
         dec_out.first.unit_valid    = 1'b1;
         dec_out.first.end_of_string = last_byte;
      end else if (gath_next < u8u16_pkg::SUPP_BASE) begin
         if (last_byte) begin
            dec_out.count = 2'd1;
            dec_out.first = marker;
         end
      end else begin
         dec_out.count                = 2'd2;
         dec_out.first.code_unit      =
            {5'd0, u8u16_pkg::HIGH_SURR_BASE + {6'd0, supp_off[19:10]}};
         dec_out.first.unit_valid     = 1'b1;
         dec_out.second.code_unit     =
            {5'd0, u8u16_pkg::LOW_SURR_BASE + {6'd0, supp_off[9:0]}};
         dec_out.second.unit_valid    = 1'b1;
         dec_out.second.end_of_string = last_byte;
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      gath_in = gath_ff;
      if (consume) begin
         if (last_byte || rem_next == u8u16_pkg::REM_NONE) begin
            rem_in  = u8u16_pkg::REM_NONE;
            gath_in = '0;
         end else begin
            rem_in  = rem_next;
            gath_in = gath_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= u8u16_pkg::REM_NONE;
         gath_ff <= '0;
      end else begin
         rem_ff  <= rem_in;
         gath_ff <= gath_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      consume && last_byte |=> rem_ff == u8u16_pkg::REM_NONE && gath_ff == '0)
      else $error("state not cleared after last byte");
   a_pair_not_utf32: assert property (@(posedge clock) disable iff (reset)
      dec_out.count == 2'd2 |-> !output_utf32 && rem_next == u8u16_pkg::REM_NONE)
      else $error("surrogate pair outside UTF-16 completion");
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !consume |=> $stable(rem_ff) && $stable(gath_ff))
      else $error("decoder state moved without a consumed byte");

endmodule

`default_nettype wire

// ===== sv/u8u16_out_queue.sv =====
// Three-entry result queue that takes zero to two results per cycle and
// presents one per transfer on the rsp channel. Depends on u8u16_pkg.
`default_nettype none

module u8u16_out_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire u8u16_pkg::decode_out_type  dec_out,
   output logic                            room,
   u8u16_rsp_if.source                     rsp
);

   function automatic logic [1:0] ptr_inc(input logic [1:0] p);
      ptr_inc = (p == 2'(u8u16_pkg::QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
   endfunction

   u8u16_pkg::result_type entry_ff [u8u16_pkg::QUEUE_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] push_cnt;
   logic       pop;

   assign push_cnt = push ? dec_out.count : 2'd0;
   assign pop      = rsp.valid && rsp.ready;
   assign room     = count_ff <= 2'd1;

   assign rsp.valid         = count_ff != 2'd0;
   assign rsp.code_unit     = entry_ff[rd_ptr_ff].code_unit;
   assign rsp.unit_valid    = entry_ff[rd_ptr_ff].unit_valid;
   assign rsp.end_of_string = entry_ff[rd_ptr_ff].end_of_string;
   assign rsp.truncated     = entry_ff[rd_ptr_ff].truncated;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_cnt == 2'd1) begin
         wr_ptr_in = ptr_inc(wr_ptr_ff);
      end else if (push_cnt == 2'd2) begin
         wr_ptr_in = ptr_inc(ptr_inc(wr_ptr_ff));
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + push_cnt - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= dec_out.first;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[ptr_inc(wr_ptr_ff)] <= dec_out.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(u8u16_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd0 |-> room)
      else $error("push without room");
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff != 2'd3 && rd_ptr_ff != 2'd3)
      else $error("queue pointer out of range");

endmodule

`default_nettype wire
